// File: hdl/ucss_pkg.sv
// Shared constants and types for the unwind code stack size parser.
`timescale 1ns / 1ps
`default_nettype none

package ucss_pkg;

    // Unwind operation codes (bits 11:8 of a slot).
    localparam logic [3:0] OP_PUSH        = 4'd0;
    localparam logic [3:0] OP_ALLOC_LARGE = 4'd1;
    localparam logic [3:0] OP_ALLOC_SMALL = 4'd2;
    localparam logic [3:0] OP_SET_FRAME   = 4'd3;
    localparam logic [3:0] OP_SAVE        = 4'd4;
    localparam logic [3:0] OP_SAVE_FAR    = 4'd5;

    // What the next slot is expected to carry.
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_SCALED = 3'd1;
    localparam logic [2:0] KIND_LOW    = 3'd2;
    localparam logic [2:0] KIND_HIGH   = 3'd3;
    localparam logic [2:0] KIND_SKIP   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SEARCH_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SEARCH_OP     = 2'd1;
    localparam logic [1:0] CFG_SEARCH_REG    = 2'd2;

    // Item kinds carried in tuser.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_SLOT   = 1'b1;

    // Slots are counted in 8-byte units, the frame offset in 16-byte units.
    localparam int SLOT_SHIFT  = 3;
    localparam int FRAME_SHIFT = 4;
    localparam int PUSH_BYTES  = 8;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_FIELD_W = 64;

    // Output tdata bit positions.
    localparam int OUT_TOTAL_LSB  = 0;
    localparam int OUT_FOUND_BIT  = 64;
    localparam int OUT_OFFSET_LSB = 65;
    localparam int OUT_TRUNC_BIT  = 129;

    typedef struct packed {
        logic [3:0] frm_offset;
        logic [3:0] frame_register;
        logic [7:0] code_count;
        logic [15:0] slot_value;
    } t_in_data;

endpackage

`default_nettype wire

// File: hdl/unwind_code_stack_size_parser_unit.sv
// Top level of the x64 unwind code stack size parser.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// s         in         i_s_tvalid/o_s_tready   tuser: command; tdata: slot, count, frame
// m         out        o_m_tvalid/i_m_tready   tdata: total, found, offset, truncated
// cfg       in         i_cfg_we                i_cfg_index, i_cfg_data
//
// One item is taken per cycle when input is not held off; the state update and the
// 64-bit running sum are done in the cycle of the transaction, and a result appears
// in the output register on the next cycle. Reset is synchronous and clears the
// search registers and the function state. When the output register holds a result
// that is not taken, input is held off until it drains or is taken that cycle.

module unwind_code_stack_size_parser_unit #(
    parameter int SIZE_WIDTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: slot_value[15:0], code_count[23:16], frame_register[27:24],
    // frm_offset[31:28]
    input  wire logic [ucss_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: command[0]
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata: total_stack_size[63:0], match_found[64], match_offset[128:65],
    // truncated[129], zero fill[135:130]
    output logic [ucss_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [1:0]                       i_cfg_index,
    input  wire logic [3:0]                       i_cfg_data
);
    import ucss_pkg::*;

    localparam int SW = SIZE_WIDTH;

    logic          r_search_en;
    logic [3:0]    r_search_op;
    logic [3:0]    r_search_reg;

    logic [SW-1:0] r_run, n_run;
    logic [7:0]    r_rem, n_rem;
    logic          r_active, n_active;
    logic [2:0]    r_kind, n_kind;
    logic [1:0]    r_skips, n_skips;
    logic [15:0]   r_low, n_low;
    logic [3:0]    r_frame_reg, n_frame_reg;
    logic [3:0]    r_frame_off, n_frame_off;
    logic          r_seen, n_seen;
    logic [SW-1:0] r_msize, n_msize;

    logic          r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    t_in_data      w_in;
    logic          w_accept;
    logic          w_emit;
    logic          w_trunc;
    logic          w_add;
    logic [SW-1:0] w_addend;
    logic [3:0]    w_op;
    logic [3:0]    w_info;

    assign w_in       = t_in_data'(i_s_tdata);
    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_op       = w_in.slot_value[11:8];
    assign w_info     = w_in.slot_value[15:12];
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_run       = r_run;
        n_rem       = r_rem;
        n_active    = r_active;
        n_kind      = r_kind;
        n_skips     = r_skips;
        n_low       = r_low;
        n_frame_reg = r_frame_reg;
        n_frame_off = r_frame_off;
        n_seen      = r_seen;
        n_msize     = r_msize;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        w_emit      = 1'b0;
        w_trunc     = 1'b0;
        w_add       = 1'b0;
        w_addend    = '0;

        if (w_accept) begin
            if (i_s_tuser == CMD_HEADER) begin
                n_run       = '0;
                n_kind      = KIND_NONE;
                n_skips     = 2'd0;
                n_low       = 16'd0;
                n_seen      = 1'b0;
                n_msize     = '0;
                n_rem       = w_in.code_count;
                n_frame_reg = w_in.frame_register;
                n_frame_off = w_in.frm_offset;
                if (w_in.code_count == 8'd0) begin
                    n_active = 1'b0;
                    w_emit   = 1'b1;
                end else begin
                    n_active = 1'b1;
                end
            end else if (r_active && r_rem != 8'd0) begin
                n_rem = r_rem - 8'd1;
                unique case (r_kind)
                    KIND_SCALED: begin
                        w_add    = 1'b1;
                        w_addend = SW'({w_in.slot_value, 3'b000});
                        n_kind   = KIND_NONE;
                    end
                    KIND_LOW: begin
                        n_low  = w_in.slot_value;
                        n_kind = KIND_HIGH;
                    end
                    KIND_HIGH: begin
                        w_add    = 1'b1;
                        w_addend = SW'({w_in.slot_value, r_low});
                        n_kind   = KIND_NONE;
                    end
                    KIND_SKIP: begin
                        if (r_skips != 2'd0) begin
                            n_skips = r_skips - 2'd1;
                        end
                        if (n_skips == 2'd0) begin
                            n_kind = KIND_NONE;
                        end
                    end
                    default: begin
                        // Only a fresh code can match; continuation slots never do.
                        if (r_search_en && w_op == r_search_op &&
                            ((w_op == OP_SET_FRAME && r_search_reg == r_frame_reg) ||
                             r_search_reg == w_info)) begin
                            n_seen  = 1'b1;
                            n_msize = r_run;
                        end
                        unique case (w_op)
                            OP_PUSH: begin
                                w_add    = 1'b1;
                                w_addend = SW'(PUSH_BYTES);
                            end
                            OP_ALLOC_LARGE: begin
                                n_kind = (w_info == 4'd0) ? KIND_SCALED : KIND_LOW;
                            end
                            OP_ALLOC_SMALL: begin
                                w_add    = 1'b1;
                                w_addend = SW'({5'({1'b0, w_info} + 5'd1), 3'b000});
                            end
                            OP_SET_FRAME: begin
                                w_add    = 1'b1;
                                w_addend = SW'(0) - (SW'(r_frame_off) << FRAME_SHIFT);
                            end
                            OP_SAVE: begin
                                n_kind  = KIND_SKIP;
                                n_skips = 2'd1;
                            end
                            OP_SAVE_FAR: begin
                                n_kind  = KIND_SKIP;
                                n_skips = 2'd2;
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
                if (w_add) begin
                    n_run = r_run + w_addend;
                end
                if (n_rem == 8'd0) begin
                    w_emit   = 1'b1;
                    w_trunc  = (n_kind == KIND_SCALED) || (n_kind == KIND_LOW) ||
                               (n_kind == KIND_HIGH);
                    n_active = 1'b0;
                    n_kind   = KIND_NONE;
                    n_skips  = 2'd0;
                end
            end
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_data[OUT_TOTAL_LSB +: OUT_FIELD_W]  = OUT_FIELD_W'(n_run);
            n_out_data[OUT_FOUND_BIT]                 = n_seen;
            n_out_data[OUT_OFFSET_LSB +: OUT_FIELD_W] =
                n_seen ? OUT_FIELD_W'(n_msize) : OUT_FIELD_W'(0);
            n_out_data[OUT_TRUNC_BIT]                 = w_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_en  <= 1'b0;
            r_search_op  <= 4'd0;
            r_search_reg <= 4'd0;
            r_run        <= '0;
            r_rem        <= 8'd0;
            r_active     <= 1'b0;
            r_kind       <= KIND_NONE;
            r_skips      <= 2'd0;
            r_low        <= 16'd0;
            r_frame_reg  <= 4'd0;
            r_frame_off  <= 4'd0;
            r_seen       <= 1'b0;
            r_msize      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SEARCH_ENABLE: r_search_en  <= i_cfg_data[0];
                    CFG_SEARCH_OP:     r_search_op  <= i_cfg_data;
                    CFG_SEARCH_REG:    r_search_reg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_run       <= n_run;
            r_rem       <= n_rem;
            r_active    <= n_active;
            r_kind      <= n_kind;
            r_skips     <= n_skips;
            r_low       <= n_low;
            r_frame_reg <= n_frame_reg;
            r_frame_off <= n_frame_off;
            r_seen      <= n_seen;
            r_msize     <= n_msize;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// File: hdl/ucss_checker.sv
// Port-level checks for the unwind code stack size parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module ucss_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic [ucss_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic                             i_s_tuser,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [ucss_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import ucss_pkg::*;

    // A result that is not taken stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Input is only held off while a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // A header with no slots gives an all-zero result on the next cycle.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == CMD_HEADER && i_s_tdata[23:16] == 8'd0
        |=> o_m_tvalid && o_m_tdata == '0)
        else $error("empty function result wrong");

    // Without a match the offset field is zero.
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[OUT_FOUND_BIT]
        |-> o_m_tdata[OUT_OFFSET_LSB +: OUT_FIELD_W] == '0)
        else $error("offset set without a match");

endmodule

bind unwind_code_stack_size_parser_unit ucss_checker u_ucss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// File: test/unwind_code_stack_size_parser_unit_test.sv
`timescale 1ns / 1ps
// Directed and randomized stream test of the unwind code stack size parser, with a local tracker.
module unwind_code_stack_size_parser_unit_test;
    import ucss_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [63:0] total;
        logic        found;
        logic [63:0] offset;
        logic        trunc;
    } stack_result_t;

    // Follows the parser state item by item and keeps the function results still owed.
    class stack_size_tracker;
        bit          search_en;
        bit [3:0]    search_op;
        bit [3:0]    search_rg;
        bit [63:0]   running;
        bit [7:0]    remaining;
        bit          active;
        bit [2:0]    kind;
        bit [1:0]    skips;
        bit [15:0]   low_half;
        bit [3:0]    freg;
        bit [3:0]    foff;
        bit          seen;
        bit [63:0]   seen_size;
        stack_result_t sizes_due[$];
        int          mismatches;

        function new();
            search_en = 1'b0;
            search_op = 4'd0;
            search_rg = 4'd0;
            mismatches = 0;
            clear_function();
        endfunction

        function void clear_function();
            running = 64'd0;
            remaining = 8'd0;
            active = 1'b0;
            kind = KIND_NONE;
            skips = 2'd0;
            low_half = 16'd0;
            freg = 4'd0;
            foff = 4'd0;
            seen = 1'b0;
            seen_size = 64'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                CFG_SEARCH_ENABLE: search_en = val[0];
                CFG_SEARCH_OP:     search_op = val;
                CFG_SEARCH_REG:    search_rg = val;
                default: ;
            endcase
        endfunction

        function void emit(bit trunc);
            stack_result_t r;
            r.total = running;
            r.found = seen;
            r.offset = seen ? seen_size : 64'd0;
            r.trunc = trunc;
            sizes_due.push_back(r);
        endfunction

        function void note_item(logic cmd, t_in_data d);
            bit [15:0] slot;
            bit [3:0]  op;
            bit [3:0]  info;
            if (cmd == CMD_HEADER) begin
                clear_function();
                remaining = d.code_count;
                freg = d.frame_register;
                foff = d.frm_offset;
                if (remaining == 0)
                    emit(1'b0);
                else
                    active = 1'b1;
                return;
            end
            if (!active || remaining == 0)
                return;
            slot = d.slot_value;
            remaining--;
            case (kind)
                KIND_SCALED: begin
                    running += {45'd0, slot, 3'd0};
                    kind = KIND_NONE;
                end
                KIND_LOW: begin
                    low_half = slot;
                    kind = KIND_HIGH;
                end
                KIND_HIGH: begin
                    running += {32'd0, slot, low_half};
                    kind = KIND_NONE;
                end
                KIND_SKIP: begin
                    if (skips != 0)
                        skips--;
                    if (skips == 0)
                        kind = KIND_NONE;
                end
                default: begin
                    op = slot[11:8];
                    info = slot[15:12];
                    // Set frame may also match on the frame register from the header.
                    if (search_en && op == search_op &&
                        ((op == OP_SET_FRAME && search_rg == freg) || search_rg == info)) begin
                        seen = 1'b1;
                        seen_size = running;
                    end
                    case (op)
                        OP_PUSH:        running += 64'd8;
                        OP_ALLOC_LARGE: kind = (info == 4'd0) ? KIND_SCALED : KIND_LOW;
                        OP_ALLOC_SMALL: running += ({60'd0, info} + 64'd1) << 3;
                        OP_SET_FRAME:   running -= {56'd0, foff, 4'd0};
                        OP_SAVE: begin
                            kind = KIND_SKIP;
                            skips = 2'd1;
                        end
                        OP_SAVE_FAR: begin
                            kind = KIND_SKIP;
                            skips = 2'd2;
                        end
                        default: ;
                    endcase
                end
            endcase
            if (remaining != 0)
                return;
            emit(kind == KIND_SCALED || kind == KIND_LOW || kind == KIND_HIGH);
            active = 1'b0;
            kind = KIND_NONE;
            skips = 2'd0;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            stack_result_t want;
            if (sizes_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, tdata);
                mismatches++;
                return;
            end
            want = sizes_due.pop_front();
            compare_field("total_stack_size", want.total, tdata[OUT_TOTAL_LSB +: 64]);
            compare_field("match_found", {63'd0, want.found}, {63'd0, tdata[OUT_FOUND_BIT]});
            compare_field("match_offset", want.offset, tdata[OUT_OFFSET_LSB +: 64]);
            compare_field("truncated", {63'd0, want.trunc}, {63'd0, tdata[OUT_TRUNC_BIT]});
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   i_m_tready;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_index;
    logic [3:0]             i_cfg_data;
    wire                    o_s_tready;
    wire                    o_m_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_tdata;

    stack_size_tracker sb;
    int   items_sent = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   rx_hold = 0;
    logic cur_en = 1'b0;
    logic [3:0] cur_op = 4'd0;
    logic [3:0] cur_rg = 4'd0;

    unwind_code_stack_size_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // A result leaving now belongs to an older item, so it is checked before the new item is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                sb.note_item(i_s_tuser, t_in_data'(i_s_tdata));
        end
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_search(logic en, logic [3:0] op, logic [3:0] rg);
        write_reg(CFG_SEARCH_ENABLE, {3'($urandom), en});
        write_reg(CFG_SEARCH_OP, op);
        write_reg(CFG_SEARCH_REG, rg);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_en = en;
        cur_op = op;
        cur_rg = rg;
    endtask

    task automatic send_item(logic cmd, t_in_data d);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    task automatic send_header(logic [7:0] count, logic [3:0] freg, logic [3:0] foff);
        t_in_data d;
        d.slot_value = 16'($urandom);
        d.code_count = count;
        d.frame_register = freg;
        d.frm_offset = foff;
        send_item(CMD_HEADER, d);
    endtask

    task automatic send_slot(logic [15:0] slot);
        t_in_data d;
        d.slot_value = slot;
        d.code_count = 8'($urandom);
        d.frame_register = 4'($urandom);
        d.frm_offset = 4'($urandom);
        send_item(CMD_SLOT, d);
    endtask

    // Waits until every result owed has left, then lets the output register settle.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.sizes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_code();
        logic [3:0] op;
        logic [3:0] info;
        int r;
        r = $urandom_range(99);
        info = 4'($urandom);
        if (cur_en && r < 20) begin
            op = cur_op;
            info = cur_rg;
        end else if (r < 85) begin
            op = 4'($urandom_range(5, 0));
        end else begin
            op = 4'($urandom_range(15, 6));
        end
        return {info, op, 8'($urandom)};
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(999);
        if (r < 2)
            return 255;
        if (r < 10)
            return $urandom_range(120, 41);
        if (r < 50)
            return 0;
        if (r < 300)
            return $urandom_range(40, 11);
        return $urandom_range(10, 1);
    endfunction

    // Builds a code list of at least n slots with continuations and sends the first sent of them.
    task automatic run_function(int n, int sent);
        logic [15:0] slots[$];
        logic [15:0] code;
        logic [3:0]  freg;
        freg = (cur_en && $urandom_range(99) < 30) ? cur_rg : 4'($urandom);
        while (slots.size() < n) begin
            code = pick_code();
            slots.push_back(code);
            if (code[11:8] == OP_ALLOC_LARGE) begin
                slots.push_back(16'($urandom));
                if (code[15:12] != 4'd0)
                    slots.push_back(16'($urandom));
            end else if (code[11:8] == OP_SAVE) begin
                slots.push_back(16'($urandom));
            end else if (code[11:8] == OP_SAVE_FAR) begin
                slots.push_back(16'($urandom));
                slots.push_back(16'($urandom));
            end
        end
        send_header(8'(n), freg, 4'($urandom));
        items_sent++;
        for (int i = 0; i < sent; i++) begin
            send_slot(slots[i]);
            items_sent++;
        end
    endtask

    task automatic random_items(int target);
        int start;
        int r;
        int n;
        start = items_sent;
        while (items_sent - start < target) begin
            r = $urandom_range(99);
            if (r < 5) begin
                // No function is open here, so this slot is dropped by the block.
                send_slot(16'($urandom));
            end else begin
                if (r < 12) begin
                    n = $urandom_range(12, 2);
                    run_function(n, $urandom_range(n - 1, 1));
                end
                n = pick_count();
                run_function(n, n);
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser = 1'b0;
        i_s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = 2'd0;
        i_cfg_data = 4'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_search(1'b1, OP_SET_FRAME, 4'd5);
        send_header(8'd0, 4'd15, 4'd15);
        send_slot(16'hF000);
        // Every size-changing operation, with the largest immediates.
        send_header(8'd8, 4'd5, 4'd15);
        send_slot(16'hF0A5);
        send_slot(16'hF23C);
        send_slot(16'h0100);
        send_slot(16'hFFFF);
        send_slot(16'h1100);
        send_slot(16'hFFFF);
        send_slot(16'hFFFF);
        send_slot(16'h0300);
        // A save far whose skipped slots lie past the count.
        send_header(8'd3, 4'd0, 4'd0);
        send_slot(16'h0400);
        send_slot(16'h5A5A);
        send_slot(16'h0500);
        // Machine frame, then a scaled large alloc cut off by the count.
        send_header(8'd2, 4'd9, 4'd3);
        send_slot(16'h0A00);
        send_slot(16'h0100);
        // Set frame on an empty sum wraps; the function is then abandoned by a new header.
        send_header(8'd2, 4'd0, 4'd15);
        send_slot(16'h5300);
        send_header(8'd1, 4'd3, 4'd1);
        send_slot(16'h2100);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 76;
                end
                default: begin
                    tx_idle_pct = 19;
                    rx_stall_pct = 19;
                end
            endcase
            for (int s = 0; s < 3; s++) begin
                case (s)
                    0: set_search(1'b0, 4'($urandom), 4'($urandom));
                    1: set_search(1'b1, 4'($urandom_range(5, 0)), 4'($urandom));
                    default: begin
                        if (p % 2 == 1)
                            set_search(1'b1, 4'd0, 4'd0);
                        else
                            set_search(1'b1, 4'd15, 4'd15);
                    end
                endcase
                if (p == 0 && s == 1)
                    rx_hold = 400;
                if (p == 1 && s == 0)
                    run_function(255, 255);
                random_items(125);
                drain();
            end
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.sizes_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/ucss_pkg.sv
hdl/unwind_code_stack_size_parser_unit.sv
hdl/ucss_checker.sv
test/unwind_code_stack_size_parser_unit_test.sv
